/* rtl/ray_cylinder_intersect_defines.svh */
// Assertion helpers shared by the block's RTL.
`ifndef RAY_CYLINDER_INTERSECT_DEFINES_SVH
`define RAY_CYLINDER_INTERSECT_DEFINES_SVH

// Clocked assertion, switched off while reset is held.
`define RCI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property of the result item whenever one is offered.
`define RCI_ASSERT_OUT(lbl, prop, msg) \
  `RCI_ASSERT(lbl, m_axis_tvalid_o |-> (prop), msg)

`endif

/* rtl/rci_pkg.sv */
`default_nettype none

package rci_pkg;

  typedef logic signed [31:0] s32_t;

  localparam s32_t S32_MAX = 32'sh7FFF_FFFF;
  localparam s32_t S32_MIN = 32'sh8000_0000;

  // Width of the exact root and quotient operands (q, -c1, c2).
  localparam int unsigned QW = 34;

  typedef enum logic [2:0] {
    CASE_TWO     = 3'd0,
    CASE_TANGENT = 3'd1,
    CASE_MISS    = 3'd2,
    CASE_SURFACE = 3'd3,
    CASE_PAR_OUT = 3'd4,
    CASE_PAR_IN  = 3'd5
  } case_e;

  typedef enum logic [2:0] {
    REG_AXIS_ORIGIN_X = 3'd0,
    REG_AXIS_ORIGIN_Y = 3'd1,
    REG_AXIS_ORIGIN_Z = 3'd2,
    REG_AXIS_DIR_X    = 3'd3,
    REG_AXIS_DIR_Y    = 3'd4,
    REG_AXIS_DIR_Z    = 3'd5,
    REG_RADIUS        = 3'd6
  } reg_e;

  typedef struct packed {
    s32_t rz;
    s32_t ry;
    s32_t rx;
    s32_t oz;
    s32_t oy;
    s32_t ox;
  } ray_t;

  typedef struct packed {
    s32_t              ax;
    s32_t              ay;
    s32_t              az;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic signed [17:0] nz;
    logic [30:0]       rad;
  } cfg_t;

  typedef struct packed {
    ray_t ray;
    s32_t c0;
    s32_t c1;
    s32_t c2;
    logic d_neg;
    logic d_zero;
  } sq_side_t;

  typedef struct packed {
    ray_t  ray;
    case_e code;
  } pt_side_t;

  function automatic s32_t ray_org(input ray_t x, input int i);
    s32_t r;
    unique case (i)
      0:       r = x.ox;
      1:       r = x.oy;
      default: r = x.oz;
    endcase
    return r;
  endfunction

  function automatic s32_t ray_dir(input ray_t x, input int i);
    s32_t r;
    unique case (i)
      0:       r = x.rx;
      1:       r = x.ry;
      default: r = x.rz;
    endcase
    return r;
  endfunction

  function automatic s32_t sat64(input logic signed [63:0] x);
    s32_t r;
    if (x > 64'sd2147483647) begin
      r = S32_MAX;
    end else if (x < -64'sd2147483648) begin
      r = S32_MIN;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic s32_t sadd(input s32_t a, input s32_t b);
    logic signed [63:0] s;
    s = 64'(a) + 64'(b);
    return sat64(s);
  endfunction

  function automatic s32_t ssub(input s32_t a, input s32_t b);
    logic signed [63:0] s;
    s = 64'(a) - 64'(b);
    return sat64(s);
  endfunction

  // Product shifted down with floor rounding, then saturated.
  function automatic s32_t qmul(input s32_t a, input s32_t b, input int unsigned f);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return sat64(p >>> f);
  endfunction

  function automatic logic [1:0] hits_of(input case_e c);
    logic [1:0] n;
    if (c == CASE_TWO) begin
      n = 2'd2;
    end else if (c == CASE_TANGENT) begin
      n = 2'd1;
    end else begin
      n = 2'd0;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

/* rtl/rci_coef.sv */
`default_nettype none

// Quadratic coefficients and discriminant, nine register stages.
module rci_coef #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire rci_pkg::ray_t      ray_i,
  input  wire rci_pkg::cfg_t      cfg_i,
  output logic                    valid_o,
  output rci_pkg::ray_t           ray_o,
  output rci_pkg::s32_t           c0_o,
  output rci_pkg::s32_t           c1_o,
  output rci_pkg::s32_t           c2_o,
  output logic signed [63:0]      d_o
);

  localparam int NS = 9;

  logic [NS-1:0] v_q;

  rci_pkg::s32_t a [3];
  rci_pkg::s32_t n [3];
  rci_pkg::s32_t rad;

  assign a[0] = cfg_i.ax;
  assign a[1] = cfg_i.ay;
  assign a[2] = cfg_i.az;
  assign n[0] = 32'(cfg_i.nx);
  assign n[1] = 32'(cfg_i.ny);
  assign n[2] = 32'(cfg_i.nz);
  assign rad  = rci_pkg::s32_t'({1'b0, cfg_i.rad});

  rci_pkg::ray_t ray1_q, ray2_q, ray3_q, ray4_q, ray5_q, ray6_q, ray7_q, ray8_q, ray9_q;
  rci_pkg::s32_t dl1_q [3];
  rci_pkg::s32_t dl2_q [3];
  rci_pkg::s32_t dl3_q [3];
  rci_pkg::s32_t dl4_q [3];
  rci_pkg::s32_t rn2_q [3];
  rci_pkg::s32_t dn2_q [3];
  rci_pkg::s32_t drn3_q, ddn3_q;
  rci_pkg::s32_t pr4_q [3];
  rci_pkg::s32_t pd4_q [3];
  rci_pkg::s32_t v5_q [3];
  rci_pkg::s32_t w5_q [3];
  rci_pkg::s32_t vv6_q [3];
  rci_pkg::s32_t vw6_q [3];
  rci_pkg::s32_t ww6_q [3];
  rci_pkg::s32_t rr6_q;
  rci_pkg::s32_t c0_7_q, c1_7_q, c2_7_q;
  rci_pkg::s32_t c0_8_q, c1_8_q, c2_8_q;
  rci_pkg::s32_t c0_9_q, c1_9_q, c2_9_q;
  logic signed [63:0] p11_8_q, p02_8_q, d9_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // offset from the axis origin
      ray1_q <= ray_i;
      for (int i = 0; i < 3; i++) begin
        dl1_q[i] <= rci_pkg::ssub(rci_pkg::ray_org(ray_i, i), a[i]);
      end
      // axis projections, term by term
      ray2_q <= ray1_q;
      for (int i = 0; i < 3; i++) begin
        dl2_q[i] <= dl1_q[i];
        rn2_q[i] <= rci_pkg::qmul(rci_pkg::ray_dir(ray1_q, i), n[i], FRAC_BITS);
        dn2_q[i] <= rci_pkg::qmul(dl1_q[i], n[i], FRAC_BITS);
      end
      ray3_q <= ray2_q;
      drn3_q <= rci_pkg::sadd(rci_pkg::sadd(rn2_q[0], rn2_q[1]), rn2_q[2]);
      ddn3_q <= rci_pkg::sadd(rci_pkg::sadd(dn2_q[0], dn2_q[1]), dn2_q[2]);
      for (int i = 0; i < 3; i++) begin
        dl3_q[i] <= dl2_q[i];
      end
      ray4_q <= ray3_q;
      for (int i = 0; i < 3; i++) begin
        dl4_q[i] <= dl3_q[i];
        pr4_q[i] <= rci_pkg::qmul(drn3_q, n[i], FRAC_BITS);
        pd4_q[i] <= rci_pkg::qmul(ddn3_q, n[i], FRAC_BITS);
      end
      // remove the axis components
      ray5_q <= ray4_q;
      for (int i = 0; i < 3; i++) begin
        v5_q[i] <= rci_pkg::ssub(rci_pkg::ray_dir(ray4_q, i), pr4_q[i]);
        w5_q[i] <= rci_pkg::ssub(dl4_q[i], pd4_q[i]);
      end
      ray6_q <= ray5_q;
      rr6_q  <= rci_pkg::qmul(rad, rad, FRAC_BITS);
      for (int i = 0; i < 3; i++) begin
        vv6_q[i] <= rci_pkg::qmul(v5_q[i], v5_q[i], FRAC_BITS);
        vw6_q[i] <= rci_pkg::qmul(v5_q[i], w5_q[i], FRAC_BITS);
        ww6_q[i] <= rci_pkg::qmul(w5_q[i], w5_q[i], FRAC_BITS);
      end
      ray7_q <= ray6_q;
      c2_7_q <= rci_pkg::sadd(rci_pkg::sadd(vv6_q[0], vv6_q[1]), vv6_q[2]);
      c1_7_q <= rci_pkg::sadd(rci_pkg::sadd(vw6_q[0], vw6_q[1]), vw6_q[2]);
      c0_7_q <= rci_pkg::ssub(rci_pkg::sadd(rci_pkg::sadd(ww6_q[0], ww6_q[1]), ww6_q[2]),
                              rr6_q);
      // exact discriminant
      ray8_q  <= ray7_q;
      c0_8_q  <= c0_7_q;
      c1_8_q  <= c1_7_q;
      c2_8_q  <= c2_7_q;
      p11_8_q <= 64'(c1_7_q) * 64'(c1_7_q);
      p02_8_q <= 64'(c0_7_q) * 64'(c2_7_q);
      ray9_q  <= ray8_q;
      c0_9_q  <= c0_8_q;
      c1_9_q  <= c1_8_q;
      c2_9_q  <= c2_8_q;
      d9_q    <= p11_8_q - p02_8_q;
    end
  end

  assign valid_o = v_q[NS-1];
  assign ray_o   = ray9_q;
  assign c0_o    = c0_9_q;
  assign c1_o    = c1_9_q;
  assign c2_o    = c2_9_q;
  assign d_o     = d9_q;

endmodule

`default_nettype wire

/* rtl/rci_sqrt.sv */
`default_nettype none

// Floor square root of a 64-bit value, one root bit per stage.
module rci_sqrt #(
  parameter int unsigned SIDE_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [63:0]       x_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic [31:0]            root_o,
  output logic [SIDE_W-1:0]      side_o
);

  localparam int NS = 32;

  logic [NS-1:0]     v_q;
  logic [63:0]       rem_q  [NS];
  logic [31:0]       root_q [NS];
  logic [SIDE_W-1:0] side_q [NS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int B = NS - 1 - k;
    logic [63:0]       rem_in;
    logic [31:0]       root_in;
    logic [SIDE_W-1:0] side_in;
    logic [64:0]       trial;

    if (k == 0) begin : g_first
      assign rem_in  = x_i;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    // (root + 2^B)^2 - root^2
    assign trial = ({33'd0, root_in} << (B + 1)) + (65'd1 << (2 * B));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
        if ({1'b0, rem_in} >= trial) begin
          rem_q[k]  <= rem_in - trial[63:0];
          root_q[k] <= root_in | (32'd1 << B);
        end else begin
          rem_q[k]  <= rem_in;
          root_q[k] <= root_in;
        end
      end
    end
  end

  assign valid_o = v_q[NS-1];
  assign root_o  = root_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

`default_nettype wire

/* rtl/rci_div.sv */
`default_nettype none

// Signed quotient truncated toward zero and saturated to 32 bits;
// restoring long division, one quotient bit per stage.
module rci_div #(
  parameter int unsigned NUM_W  = 50,
  parameter int unsigned DEN_W  = 34,
  parameter int unsigned SIDE_W = 8
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    valid_i,
  input  wire logic signed [NUM_W-1:0] num_i,
  input  wire logic signed [DEN_W-1:0] den_i,
  input  wire logic [SIDE_W-1:0]       side_i,
  output logic                         valid_o,
  output rci_pkg::s32_t                quo_o,
  output logic [SIDE_W-1:0]            side_o
);

  localparam int QB = 33;
  localparam int RW = (NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB;
  localparam int NS = QB + 2;

  typedef struct packed {
    logic neg;
    logic num_pos;
    logic num_neg;
    logic den_zero;
    logic ovf;
  } dflag_t;

  logic [NS-1:0] v_q;

  logic [NUM_W-1:0] nmag;
  logic [DEN_W-1:0] dmag;
  dflag_t           fl_d;

  assign nmag = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
  assign dmag = den_i[DEN_W-1] ? DEN_W'(-den_i) : DEN_W'(den_i);

  always_comb begin
    fl_d.neg      = num_i[NUM_W-1] ^ den_i[DEN_W-1];
    fl_d.num_pos  = !num_i[NUM_W-1] && (num_i != '0);
    fl_d.num_neg  = num_i[NUM_W-1];
    fl_d.den_zero = (den_i == '0);
    fl_d.ovf      = RW'(nmag) >= (RW'(dmag) << QB);
  end

  logic [RW-1:0]     rem_q  [QB+1];
  logic [QB-1:0]     quo_q  [QB+1];
  logic [DEN_W-1:0]  dm_q   [QB+1];
  dflag_t            fl_q   [QB+1];
  logic [SIDE_W-1:0] side_q [QB+1];
  rci_pkg::s32_t     res_q;
  logic [SIDE_W-1:0] side_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= RW'(nmag);
      quo_q[0]  <= '0;
      dm_q[0]   <= dmag;
      fl_q[0]   <= fl_d;
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int B = QB - 1 - k;
    logic [RW-1:0] trial;

    assign trial = RW'(dm_q[k]) << B;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dm_q[k+1]   <= dm_q[k];
        fl_q[k+1]   <= fl_q[k];
        side_q[k+1] <= side_q[k];
        if (rem_q[k] >= trial) begin
          rem_q[k+1] <= rem_q[k] - trial;
          quo_q[k+1] <= quo_q[k] | (QB'(1) << B);
        end else begin
          rem_q[k+1] <= rem_q[k];
          quo_q[k+1] <= quo_q[k];
        end
      end
    end
  end

  logic [QB-1:0]  qm;
  logic [QB-1:0]  qneg;
  dflag_t         fl_l;
  rci_pkg::s32_t  res_d;

  assign qm   = quo_q[QB];
  assign qneg = (~qm) + QB'(1);
  assign fl_l = fl_q[QB];

  always_comb begin
    priority if (fl_l.den_zero) begin
      res_d = fl_l.num_pos ? rci_pkg::S32_MAX :
              fl_l.num_neg ? rci_pkg::S32_MIN : '0;
    end else if (fl_l.ovf) begin
      res_d = fl_l.neg ? rci_pkg::S32_MIN : rci_pkg::S32_MAX;
    end else if (fl_l.neg) begin
      res_d = (qm > QB'(33'd2147483648)) ? rci_pkg::S32_MIN : qneg[31:0];
    end else begin
      res_d = (qm > QB'(33'd2147483647)) ? rci_pkg::S32_MAX : qm[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q      <= res_d;
      side_out_q <= side_q[QB];
    end
  end

  assign valid_o = v_q[NS-1];
  assign quo_o   = res_q;
  assign side_o  = side_out_q;

endmodule

`default_nettype wire

/* rtl/ray_cylinder_intersect.sv */
// Ray against infinite cylinder, fixed-point Q(FRAC_BITS), fully pipelined.
// Stages from an accepted ray to its result item: 9 coefficient stages, 32 square-root
// stages, 1 root-pair stage, 35 divider stages, 3 point stages.
// Throughput: one ray per cycle; the whole pipe holds while a result waits unaccepted.
// Reset (rst_ni low, asynchronous): all stage valids clear, registers return to
// axis origin 0, axis direction (0,0,1.0) and radius 1.0.
`default_nettype none
`include "ray_cylinder_intersect_defines.svh"

module ray_cylinder_intersect #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // register write channel
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i,
  // ray items
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // ray_origin_x, ray_origin_y, ray_origin_z, ray_dir_x, ray_dir_y, ray_dir_z
  input  wire logic [191:0] s_axis_tdata_i,
  // result items
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // hit_count, entry_x, entry_y, entry_z, exit_x, exit_y, exit_z, zero fill
  output logic [199:0]      m_axis_tdata_o,
  // case_code
  output logic [2:0]        m_axis_tuser_o
);

  localparam int unsigned QW    = rci_pkg::QW;
  localparam int unsigned NUM_W = QW + FRAC_BITS;
  localparam int unsigned SQ_W  = $bits(rci_pkg::sq_side_t);
  localparam int unsigned PT_W  = $bits(rci_pkg::pt_side_t);

  // Every stage advances together; hold the lot while the output item waits.
  logic adv;
  logic out_v_q;

  assign adv             = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign cfg_ready_o     = 1'b1;

  // ---------------------------------------------------------------------------
  // Registers. Writes must arrive only while the pipe is empty; the block does not enforce it.
  // ---------------------------------------------------------------------------
  rci_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ax  <= '0;
      cfg_q.ay  <= '0;
      cfg_q.az  <= '0;
      cfg_q.nx  <= '0;
      cfg_q.ny  <= '0;
      cfg_q.nz  <= 18'sd65536;
      cfg_q.rad <= 31'd65536;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rci_pkg::REG_AXIS_ORIGIN_X: cfg_q.ax  <= cfg_data_i;
        rci_pkg::REG_AXIS_ORIGIN_Y: cfg_q.ay  <= cfg_data_i;
        rci_pkg::REG_AXIS_ORIGIN_Z: cfg_q.az  <= cfg_data_i;
        rci_pkg::REG_AXIS_DIR_X:    cfg_q.nx  <= cfg_data_i[17:0];
        rci_pkg::REG_AXIS_DIR_Y:    cfg_q.ny  <= cfg_data_i[17:0];
        rci_pkg::REG_AXIS_DIR_Z:    cfg_q.nz  <= cfg_data_i[17:0];
        rci_pkg::REG_RADIUS:        cfg_q.rad <= cfg_data_i[30:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Coefficients c2, c1, c0 and the exact discriminant.
  // ---------------------------------------------------------------------------
  rci_pkg::ray_t      ray_in;
  logic               cf_v;
  rci_pkg::ray_t      cf_ray;
  rci_pkg::s32_t      cf_c0, cf_c1, cf_c2;
  logic signed [63:0] cf_d;

  assign ray_in = rci_pkg::ray_t'(s_axis_tdata_i);

  rci_coef #(
    .FRAC_BITS (FRAC_BITS)
  ) u_coef (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s_axis_tvalid_i),
    .ray_i   (ray_in),
    .cfg_i   (cfg_q),
    .valid_o (cf_v),
    .ray_o   (cf_ray),
    .c0_o    (cf_c0),
    .c1_o    (cf_c1),
    .c2_o    (cf_c2),
    .d_o     (cf_d)
  );

  // ---------------------------------------------------------------------------
  // Square root of d; a negative d is fed as zero and only its sign is kept.
  // ---------------------------------------------------------------------------
  rci_pkg::sq_side_t sq_in, sq_out;
  logic [SQ_W-1:0]   sq_side_raw;
  logic [63:0]       sq_x;
  logic              sq_v;
  logic [31:0]       sq_root;

  always_comb begin
    sq_in.ray    = cf_ray;
    sq_in.c0     = cf_c0;
    sq_in.c1     = cf_c1;
    sq_in.c2     = cf_c2;
    sq_in.d_neg  = cf_d[63];
    sq_in.d_zero = (cf_d == '0);
  end

  assign sq_x = cf_d[63] ? 64'd0 : cf_d;

  rci_sqrt #(
    .SIDE_W (SQ_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (cf_v),
    .x_i     (sq_x),
    .side_i  (SQ_W'(sq_in)),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .side_o  (sq_side_raw)
  );

  assign sq_out = rci_pkg::sq_side_t'(sq_side_raw);

  // ---------------------------------------------------------------------------
  // Stable root pair and case selection. q = -c1 - sgn(c1) sqrt(d), with the
  // sign of zero taken as negative. The tangent case reuses divider A for -c1/c2.
  // ---------------------------------------------------------------------------
  logic signed [QW-1:0] s_ext, negc1, q_d;
  rci_pkg::case_e       code_d;

  assign s_ext = QW'({1'b0, sq_root});
  assign negc1 = -QW'(sq_out.c1);
  assign q_d   = (sq_out.c1 > 0) ? (negc1 - s_ext) : (negc1 + s_ext);

  always_comb begin
    priority if (sq_out.d_neg) begin
      code_d = rci_pkg::CASE_MISS;
    end else if (!sq_out.d_zero) begin
      code_d = rci_pkg::CASE_TWO;
    end else if (sq_out.c2 != 0) begin
      code_d = rci_pkg::CASE_TANGENT;
    end else if (sq_out.c0 == 0) begin
      code_d = rci_pkg::CASE_SURFACE;
    end else if (sq_out.c0 > 0) begin
      code_d = rci_pkg::CASE_PAR_OUT;
    end else begin
      code_d = rci_pkg::CASE_PAR_IN;
    end
  end

  logic                    rp_v_q;
  logic signed [NUM_W-1:0] num_a_q, num_b_q;
  logic signed [QW-1:0]    den_a_q, den_b_q;
  rci_pkg::pt_side_t       rp_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_v_q <= 1'b0;
    end else if (adv) begin
      rp_v_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_a_q <= NUM_W'((code_d == rci_pkg::CASE_TWO) ? q_d : negc1) <<< FRAC_BITS;
      den_a_q <= QW'(sq_out.c2);
      num_b_q <= NUM_W'(sq_out.c0) <<< FRAC_BITS;
      den_b_q <= q_d;
      rp_side_q.ray  <= sq_out.ray;
      rp_side_q.code <= code_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Dividers: t1 = q / c2 (or -c1 / c2 when tangent), t2 = c0 / q.
  // ---------------------------------------------------------------------------
  logic              dv_v;
  rci_pkg::s32_t     t1, t2;
  logic [PT_W-1:0]   dv_side_raw;
  rci_pkg::pt_side_t dv_side;

  rci_div #(
    .NUM_W  (NUM_W),
    .DEN_W  (QW),
    .SIDE_W (PT_W)
  ) u_div_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (rp_v_q),
    .num_i   (num_a_q),
    .den_i   (den_a_q),
    .side_i  (PT_W'(rp_side_q)),
    .valid_o (dv_v),
    .quo_o   (t1),
    .side_o  (dv_side_raw)
  );

  rci_div #(
    .NUM_W  (NUM_W),
    .DEN_W  (QW),
    .SIDE_W (1)
  ) u_div_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (rp_v_q),
    .num_i   (num_b_q),
    .den_i   (den_b_q),
    .side_i  (1'b0),
    .valid_o (),
    .quo_o   (t2),
    .side_o  ()
  );

  assign dv_side = rci_pkg::pt_side_t'(dv_side_raw);

  // ---------------------------------------------------------------------------
  // Order by t, scale the direction, add the origin.
  // ---------------------------------------------------------------------------
  logic              od_v_q;
  rci_pkg::s32_t     tlo_q, thi_q;
  rci_pkg::pt_side_t od_side_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      od_side_q <= dv_side;
      if ((dv_side.code == rci_pkg::CASE_TWO) && (t2 < t1)) begin
        tlo_q <= t2;
        thi_q <= t1;
      end else if (dv_side.code == rci_pkg::CASE_TWO) begin
        tlo_q <= t1;
        thi_q <= t2;
      end else begin
        // tangent: both points at the single root
        tlo_q <= t1;
        thi_q <= t1;
      end
    end
  end

  logic              sc_v_q;
  rci_pkg::s32_t     mlo_q [3];
  rci_pkg::s32_t     mhi_q [3];
  rci_pkg::pt_side_t sc_side_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sc_side_q <= od_side_q;
      for (int i = 0; i < 3; i++) begin
        mlo_q[i] <= rci_pkg::qmul(tlo_q, rci_pkg::ray_dir(od_side_q.ray, i), FRAC_BITS);
        mhi_q[i] <= rci_pkg::qmul(thi_q, rci_pkg::ray_dir(od_side_q.ray, i), FRAC_BITS);
      end
    end
  end

  rci_pkg::s32_t  ent_q [3];
  rci_pkg::s32_t  ext_q [3];
  rci_pkg::case_e code_q;
  logic [1:0]     hits_q;
  logic [1:0]     hits_d;

  assign hits_d = rci_pkg::hits_of(sc_side_q.code);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      code_q <= sc_side_q.code;
      hits_q <= hits_d;
      for (int i = 0; i < 3; i++) begin
        // zero the points when there is no hit
        if (hits_d == 2'd0) begin
          ent_q[i] <= '0;
          ext_q[i] <= '0;
        end else begin
          ent_q[i] <= rci_pkg::sadd(rci_pkg::ray_org(sc_side_q.ray, i), mlo_q[i]);
          ext_q[i] <= rci_pkg::sadd(rci_pkg::ray_org(sc_side_q.ray, i), mhi_q[i]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      od_v_q  <= 1'b0;
      sc_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      od_v_q  <= dv_v;
      sc_v_q  <= od_v_q;
      out_v_q <= sc_v_q;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tuser_o  = code_q;
  assign m_axis_tdata_o  = {6'd0, ext_q[2], ext_q[1], ext_q[0],
                            ent_q[2], ent_q[1], ent_q[0], hits_q};

  // ---------------------------------------------------------------------------
  // Checks on the result item.
  // ---------------------------------------------------------------------------
  `RCI_ASSERT_OUT(a_count_matches_code, ((m_axis_tuser_o == rci_pkg::CASE_TWO) == (m_axis_tdata_o[1:0] == 2'd2)) && ((m_axis_tuser_o == rci_pkg::CASE_TANGENT) == (m_axis_tdata_o[1:0] == 2'd1)), "hit count disagrees with case code")
  `RCI_ASSERT_OUT(a_tangent_same_point, (m_axis_tuser_o != rci_pkg::CASE_TANGENT) || (m_axis_tdata_o[97:2] == m_axis_tdata_o[193:98]), "tangent entry and exit differ")
  `RCI_ASSERT_OUT(a_nohit_zero, (m_axis_tdata_o[1:0] != 2'd0) || (m_axis_tdata_o[193:2] == '0), "points not cleared without a hit")

endmodule

`default_nettype wire

/* verif/ray_cylinder_intersect_tb.sv */
`default_nettype none

module ray_cylinder_intersect_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC   = 16;
  localparam longint      ONE    = 65536;
  localparam int          LATENCY = 80;
  localparam longint      CYCLE_LIMIT = 600000;
  localparam logic [2:0]  REG_UNUSED = 3'd7;
  localparam int          N_PHASES = 10;
  localparam int          RAYS_PER_PHASE = 70;

  typedef struct {
    rci_pkg::case_e code;
    logic [1:0]     hits;
    rci_pkg::s32_t  ent [3];
    rci_pkg::s32_t  ext [3];
  } hit_result_t;

  // Hit predictor: holds its own copy of the cylinder registers and the
  // results still owed by the block.
  class hit_scoreboard;
    longint      org [3];
    longint      dir [3];
    longint      rad;
    hit_result_t owed [$];
    int          errors;

    function new();
      org = '{0, 0, 0};
      dir = '{0, 0, ONE};
      rad = ONE;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        rci_pkg::REG_AXIS_ORIGIN_X: org[0] = longint'($signed(data));
        rci_pkg::REG_AXIS_ORIGIN_Y: org[1] = longint'($signed(data));
        rci_pkg::REG_AXIS_ORIGIN_Z: org[2] = longint'($signed(data));
        rci_pkg::REG_AXIS_DIR_X:    dir[0] = longint'($signed(data[17:0]));
        rci_pkg::REG_AXIS_DIR_Y:    dir[1] = longint'($signed(data[17:0]));
        rci_pkg::REG_AXIS_DIR_Z:    dir[2] = longint'($signed(data[17:0]));
        rci_pkg::REG_RADIUS:        rad    = longint'({1'b0, data[30:0]});
        default: ;
      endcase
    endfunction

    function longint clip(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    // Floor-rounded fixed-point product, saturated.
    function longint fmul(longint a, longint b);
      longint p;
      p = a * b;
      return clip(p >>> FRAC);
    endfunction

    function longint fdot(longint a [3], longint b [3]);
      return clip(clip(fmul(a[0], b[0]) + fmul(a[1], b[1])) + fmul(a[2], b[2]));
    endfunction

    function longint fdiv(longint num, longint den);
      if (den == 0) begin
        if (num > 0) return 64'sd2147483647;
        if (num < 0) return -64'sd2147483648;
        return 0;
      end
      return clip((num * ONE) / den);
    endfunction

    function longint unsigned root(longint unsigned x);
      longint unsigned res, b;
      res = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    // Predict the result for one accepted ray.
    function void note_ray(rci_pkg::ray_t ray);
      longint o [3], r [3], dl [3], v [3], w [3];
      longint e [3], x [3];
      longint drn, ddn, c2, c1, c0, d, s, q, t1, t2, tmp;
      hit_result_t res;
      o = '{longint'(ray.ox), longint'(ray.oy), longint'(ray.oz)};
      r = '{longint'(ray.rx), longint'(ray.ry), longint'(ray.rz)};
      e = '{0, 0, 0};
      x = '{0, 0, 0};
      for (int i = 0; i < 3; i++) dl[i] = clip(o[i] - org[i]);
      drn = fdot(r, dir);
      ddn = fdot(dl, dir);
      for (int i = 0; i < 3; i++) begin
        v[i] = clip(r[i] - fmul(drn, dir[i]));
        w[i] = clip(dl[i] - fmul(ddn, dir[i]));
      end
      c2 = fdot(v, v);
      c1 = fdot(v, w);
      c0 = clip(fdot(w, w) - fmul(rad, rad));
      d = c1 * c1 - c0 * c2;
      if (d < 0) begin
        res.code = rci_pkg::CASE_MISS;
      end else if (d > 0) begin
        s = longint'(root(longint'(d)));
        q = (c1 > 0) ? (-c1 - s) : (-c1 + s);
        t1 = fdiv(q, c2);
        if (q == 0) t2 = fdiv(c0, 0);
        else t2 = clip((c0 * ONE) / q);
        if (t2 < t1) begin
          tmp = t1; t1 = t2; t2 = tmp;
        end
        for (int i = 0; i < 3; i++) begin
          e[i] = clip(o[i] + fmul(t1, r[i]));
          x[i] = clip(o[i] + fmul(t2, r[i]));
        end
        res.code = rci_pkg::CASE_TWO;
      end else if (c2 != 0) begin
        t1 = fdiv(-c1, c2);
        for (int i = 0; i < 3; i++) begin
          e[i] = clip(o[i] + fmul(t1, r[i]));
          x[i] = e[i];
        end
        res.code = rci_pkg::CASE_TANGENT;
      end else if (c0 == 0) begin
        res.code = rci_pkg::CASE_SURFACE;
      end else if (c0 > 0) begin
        res.code = rci_pkg::CASE_PAR_OUT;
      end else begin
        res.code = rci_pkg::CASE_PAR_IN;
      end
      res.hits = (res.code == rci_pkg::CASE_TWO)     ? 2'd2 :
                 (res.code == rci_pkg::CASE_TANGENT) ? 2'd1 : 2'd0;
      for (int i = 0; i < 3; i++) begin
        res.ent[i] = e[i][31:0];
        res.ext[i] = x[i][31:0];
      end
      owed.push_back(res);
    endfunction

    function void cmp(string name, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [199:0] data, logic [2:0] user);
      hit_result_t w;
      if (owed.size() == 0) begin
        $error("result item with no ray outstanding");
        errors++;
        return;
      end
      w = owed.pop_front();
      cmp("case_code", w.code, user);
      cmp("hit_count", w.hits, data[1:0]);
      cmp("entry_x", w.ent[0], $signed(data[2 +: 32]));
      cmp("entry_y", w.ent[1], $signed(data[34 +: 32]));
      cmp("entry_z", w.ent[2], $signed(data[66 +: 32]));
      cmp("exit_x", w.ext[0], $signed(data[98 +: 32]));
      cmp("exit_y", w.ext[1], $signed(data[130 +: 32]));
      cmp("exit_z", w.ext[2], $signed(data[162 +: 32]));
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_valid;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_data;
  logic         s_tvalid;
  logic [191:0] s_tdata;
  logic         m_tready;
  logic         cfg_ready_o;
  logic         s_axis_tready_o;
  logic         m_axis_tvalid_o;
  logic [199:0] m_axis_tdata_o;
  logic [2:0]   m_axis_tuser_o;

  hit_scoreboard sb;
  bit     quiet;
  int     stall_left;
  longint cycles;

  ray_cylinder_intersect #(.FRAC_BITS(FRAC)) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Note accepted rays and check result items, both on edge-sampled values.
  always @(posedge clk_i) begin
    if (rst_ni && s_tvalid && s_axis_tready_o) sb.note_ray(rci_pkg::ray_t'(s_tdata));
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
    end
  end

  // Receiver back-pressure: random stall bursts, none in the final stretch.
  always @(posedge clk_i) begin
    if (!rst_ni || quiet) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 14);
    end else begin
      m_tready   <= 1'b1;
      stall_left <= $urandom_range(0, 20);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Write one register; valid stays high for a following write.
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  task automatic send_ray(rci_pkg::ray_t ray);
    s_tvalid <= 1'b1;
    s_tdata  <= ray;
    do @(posedge clk_i); while (!s_axis_tready_o);
    // Occasionally drop valid for a burst between rays.
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.owed.size() != 0);
  endtask

  function automatic rci_pkg::s32_t near_val(longint base, longint span);
    longint v;
    v = base + $signed($urandom_range(0, 32'(2 * span))) - span;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // Mostly rays near the axis origin, some parallel to the axis, some noise.
  function automatic rci_pkg::ray_t rand_ray();
    rci_pkg::ray_t r;
    int            kind;
    longint        k;
    kind = $urandom_range(0, 9);
    r.ox = near_val(sb.org[0], 8 * ONE);
    r.oy = near_val(sb.org[1], 8 * ONE);
    r.oz = near_val(sb.org[2], 8 * ONE);
    r.rx = near_val(0, 4 * ONE);
    r.ry = near_val(0, 4 * ONE);
    r.rz = near_val(0, 4 * ONE);
    if (kind <= 1) begin
      r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else if (kind == 2) begin
      k = $signed($urandom_range(0, 8)) - 4;
      r.rx = 32'(k * sb.dir[0]);
      r.ry = 32'(k * sb.dir[1]);
      r.rz = 32'(k * sb.dir[2]);
    end
    return r;
  endfunction

  function automatic logic [31:0] pick_dir();
    case ($urandom_range(0, 5))
      0: return 32'(-131072);
      1: return 32'(131071);
      2: return $urandom;
      default: return ($urandom_range(0, 1) != 0) ? 32'(65536) : 32'(-65536);
    endcase
  endfunction

  task automatic set_cylinder(int phase);
    logic [31:0] dval [3];
    int          ax;
    ax = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) dval[i] = '0;
    dval[ax] = ($urandom_range(0, 1) != 0) ? 32'(65536) : 32'(-65536);
    if (phase % 3 == 2) begin
      for (int i = 0; i < 3; i++) dval[i] = pick_dir();
    end
    write_reg(rci_pkg::REG_AXIS_DIR_X, dval[0]);
    write_reg(rci_pkg::REG_AXIS_DIR_Y, dval[1]);
    write_reg(rci_pkg::REG_AXIS_DIR_Z, dval[2]);
    case (phase % 4)
      0: begin
        write_reg(rci_pkg::REG_AXIS_ORIGIN_X, 32'h7FFF_FFFF);
        write_reg(rci_pkg::REG_AXIS_ORIGIN_Y, 32'h8000_0000);
        write_reg(rci_pkg::REG_AXIS_ORIGIN_Z, $urandom);
      end
      default: begin
        write_reg(rci_pkg::REG_AXIS_ORIGIN_X, near_val(0, 16 * ONE));
        write_reg(rci_pkg::REG_AXIS_ORIGIN_Y, near_val(0, 16 * ONE));
        write_reg(rci_pkg::REG_AXIS_ORIGIN_Z, near_val(0, 16 * ONE));
      end
    endcase
    case (phase % 5)
      0: write_reg(rci_pkg::REG_RADIUS, 32'h7FFF_FFFF);
      1: write_reg(rci_pkg::REG_RADIUS, 32'h0);
      2: write_reg(rci_pkg::REG_RADIUS, $urandom);
      default: write_reg(rci_pkg::REG_RADIUS, $urandom_range(0, 32'(8 * ONE)));
    endcase
    // Index past the register list must be ignored.
    if (phase % 3 == 0) write_reg(REG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic rci_pkg::ray_t mk(longint ox, longint oy, longint oz,
                                       longint rx, longint ry, longint rz);
    rci_pkg::ray_t r;
    r.ox = ox[31:0]; r.oy = oy[31:0]; r.oz = oz[31:0];
    r.rx = rx[31:0]; r.ry = ry[31:0]; r.rz = rz[31:0];
    return r;
  endfunction

  initial begin
    rci_pkg::ray_t directed [$];
    sb         = new();
    quiet      = 1'b0;
    stall_left = 0;
    cycles     = 0;
    rst_ni     = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    m_tready   = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset cylinder: unit radius round the z axis.
    directed.push_back(mk(-2 * ONE, 0, 0, ONE, 0, 0));          // two hits
    directed.push_back(mk(-2 * ONE, ONE, 0, ONE, 0, 0));        // tangent
    directed.push_back(mk(-2 * ONE, 2 * ONE, 0, ONE, 0, 0));    // miss
    directed.push_back(mk(ONE, 0, 0, 0, 0, ONE));               // along the surface
    directed.push_back(mk(3 * ONE, 0, 0, 0, 0, -ONE));          // parallel outside
    directed.push_back(mk(0, 0, 5 * ONE, 0, 0, 2 * ONE));       // parallel inside
    directed.push_back(mk(0, 0, 0, 0, 0, 0));                   // null direction
    directed.push_back(mk(0, 0, 0, ONE, ONE, 0));               // from inside
    directed.push_back({6{32'h7FFF_FFFF}});
    directed.push_back({6{32'h8000_0000}});
    directed.push_back({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
    directed.push_back(mk(-2 * ONE, 0, 0, 1, 0, 0));            // tiny direction
    directed.push_back(mk(0, 0, 0, 32'sh7FFF_FFFF, 0, 0));
    directed.push_back({6{32'hFFFF_FFFF}});
    foreach (directed[i]) send_ray(directed[i]);
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      set_cylinder(p);
      if (p == N_PHASES - 1) quiet = 1'b1;
      for (int i = 0; i < RAYS_PER_PHASE; i++) send_ray(rand_ray());
      drain();
    end

    // Back to a plain unit cylinder for a final burst at full rate.
    write_reg(rci_pkg::REG_AXIS_ORIGIN_X, '0);
    write_reg(rci_pkg::REG_AXIS_ORIGIN_Y, '0);
    write_reg(rci_pkg::REG_AXIS_ORIGIN_Z, '0);
    write_reg(rci_pkg::REG_AXIS_DIR_X, '0);
    write_reg(rci_pkg::REG_AXIS_DIR_Y, '0);
    write_reg(rci_pkg::REG_AXIS_DIR_Z, 32'(65536));
    write_reg(rci_pkg::REG_RADIUS, 32'(65536));
    cfg_valid <= 1'b0;
    for (int i = 0; i < 40; i++) send_ray(rand_ray());
    drain();
    repeat (LATENCY + 20) @(posedge clk_i);

    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
